// ===== design/itc_pkg.sv =====
// Shared types, constants and decode helpers for the interrupt controller with timers.
`default_nettype none

package itc_pkg;

    localparam int TIMER_COUNT     = 3;
    localparam int TIMER_IRQ_FIRST = 4;
    localparam int REGS_PER_CHAN   = 9;
    localparam int SLOT_W          = $clog2(REGS_PER_CHAN);
    localparam int STATUS_BIT      = 4;

    localparam logic [SLOT_W-1:0] SLOT_CCR = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_RC  = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_SR  = SLOT_W'(5);

    localparam logic [31:0] ADDR_IVR   = 32'hfffff100;
    localparam logic [31:0] ADDR_LVR   = 32'hfffff108;
    localparam logic [31:0] ADDR_IMR_A = 32'hfffff110;
    localparam logic [31:0] ADDR_IMR_B = 32'hfffff114;
    localparam logic [31:0] ADDR_IECR  = 32'hfffff120;
    localparam logic [31:0] ADDR_IDCR  = 32'hfffff124;
    localparam logic [31:0] ADDR_ICCR  = 32'hfffff128;
    localparam logic [31:0] ADDR_ID    = 32'hfff00000;
    localparam logic [23:0] TIMER_PAGE = 24'hfffe00;

    localparam logic [31:0] ID_WORD    = 32'h14000040;
    localparam logic [31:0] ALL_ONES   = 32'hffffffff;
    localparam logic [31:0] FIQ_MASK   = 32'h00001;
    localparam logic [31:0] IRQ_MASK   = 32'h3fffe;
    localparam logic [15:0] COUNT_MAX  = 16'hffff;
    localparam logic [15:0] COUNT_WARN = 16'h1000;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_RAISE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [4:0]  source;
    } t_item;

    typedef struct packed {
        logic [31:0] rdata;
        logic        fiq_request;
        logic        irq_request;
    } t_result;

    typedef struct packed {
        logic              hit;
        logic              is_cv;
        logic [SLOT_W-1:0] idx;
    } t_slot;

    function automatic t_slot slot_of(input logic [5:0] off);
        t_slot s;
        s = '{hit: 1'b1, is_cv: 1'b0, idx: '0};
        case (off)
            6'h00: s.idx = SLOT_W'(0);
            6'h04: s.idx = SLOT_W'(1);
            6'h10: s.is_cv = 1'b1;
            6'h14: s.idx = SLOT_W'(2);
            6'h18: s.idx = SLOT_W'(3);
            6'h1c: s.idx = SLOT_W'(4);
            6'h20: s.idx = SLOT_W'(5);
            6'h24: s.idx = SLOT_W'(6);
            6'h28: s.idx = SLOT_W'(7);
            6'h2c: s.idx = SLOT_W'(8);
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== design/itc_in_reg.sv =====
// Input register that captures one item and holds it until the core takes it.
`default_nettype none

module itc_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire itc_pkg::t_item i_item,
    input  wire logic          i_take,
    output logic               o_valid,
    output itc_pkg::t_item     o_item
);
    import itc_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/itc_core.sv =====
// Controller and timer state with the single-pass update for one item.
`default_nettype none

module itc_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire itc_pkg::t_item i_item,
    output itc_pkg::t_result    o_result
);
    import itc_pkg::*;

    logic [31:0] r_pending;
    logic [31:0] r_mask;
    logic [31:0] r_last_vector;
    logic [15:0] r_count   [TIMER_COUNT];
    logic [15:0] r_reload  [TIMER_COUNT];
    logic        r_rld_en  [TIMER_COUNT];
    logic [31:0] r_chan    [TIMER_COUNT][REGS_PER_CHAN];

    logic [31:0] n_pending;
    logic [31:0] n_mask;
    logic [31:0] n_last_vector;
    logic [15:0] n_count   [TIMER_COUNT];
    logic [15:0] n_reload  [TIMER_COUNT];
    logic        n_rld_en  [TIMER_COUNT];
    logic [31:0] n_chan    [TIMER_COUNT][REGS_PER_CHAN];

    t_slot       slot;
    logic [1:0]  ch;
    logic        timer_hit;
    logic [4:0]  vec;
    logic [31:0] rdata;
    logic [31:0] req;

    assign slot      = slot_of(i_item.addr[5:0]);
    assign ch        = i_item.addr[7:6];
    assign timer_hit = (i_item.addr[31:8] == TIMER_PAGE) && (ch < 2'(TIMER_COUNT)) && slot.hit;
    assign vec       = lowest_set(r_pending);

    always_comb begin
        n_pending     = r_pending;
        n_mask        = r_mask;
        n_last_vector = r_last_vector;
        n_count       = r_count;
        n_reload      = r_reload;
        n_rld_en      = r_rld_en;
        n_chan        = r_chan;
        rdata         = '0;
        case (t_kind'(i_item.kind))
            KIND_TICK: begin
                for (int t = 0; t < TIMER_COUNT; t++) begin
                    if (r_count[t] == '0) begin
                        n_count[t] = r_rld_en[t] ? r_reload[t] : COUNT_MAX;
                        n_pending[5'((TIMER_IRQ_FIRST + t) % 32)] = 1'b1;
                        n_chan[t][SLOT_SR][STATUS_BIT] = 1'b1;
                    end else begin
                        n_count[t] = r_count[t] - 16'd1;
                        if (n_count[t] == COUNT_WARN) begin
                            n_chan[t][SLOT_SR][STATUS_BIT] = 1'b1;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (timer_hit) begin
                    if (slot.is_cv) begin
                        rdata = {16'h0, r_count[ch]};
                    end else begin
                        rdata = r_chan[ch][slot.idx];
                        if (slot.idx == SLOT_SR) begin
                            n_chan[ch][SLOT_SR][STATUS_BIT] = 1'b0;
                        end
                    end
                end else begin
                    case (i_item.addr)
                        ADDR_IVR: begin
                            rdata         = {27'h0, vec};
                            n_last_vector = {27'h0, vec};
                            if (r_pending != '0) begin
                                n_pending[vec] = 1'b0;
                            end
                        end
                        ADDR_LVR:   rdata = r_last_vector;
                        ADDR_IMR_A: rdata = r_mask;
                        ADDR_IMR_B: rdata = r_mask;
                        ADDR_IECR:  rdata = r_mask;
                        ADDR_ID:    rdata = ID_WORD;
                        default:    rdata = ALL_ONES;
                    endcase
                end
            end
            KIND_WRITE: begin
                if (timer_hit) begin
                    if (slot.is_cv || slot.idx == SLOT_RC) begin
                        n_count[ch]  = i_item.wdata[15:0];
                        n_reload[ch] = i_item.wdata[15:0];
                    end
                    if (!slot.is_cv) begin
                        n_chan[ch][slot.idx] = i_item.wdata;
                        if (slot.idx == SLOT_CCR) begin
                            n_rld_en[ch] = !i_item.wdata[1];
                        end
                    end
                end else begin
                    case (i_item.addr)
                        ADDR_IECR: n_mask    = r_mask | i_item.wdata;
                        ADDR_IDCR: n_mask    = r_mask & ~i_item.wdata;
                        ADDR_ICCR: n_pending = r_pending & ~i_item.wdata;
                        default: ;
                    endcase
                end
            end
            KIND_RAISE: begin
                n_pending[i_item.source] = 1'b1;
            end
            default: ;
        endcase
    end

    assign req = n_pending & n_mask;

    always_comb begin
        o_result.rdata       = rdata;
        o_result.fiq_request = |(req & FIQ_MASK);
        o_result.irq_request = |(req & IRQ_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending     <= '0;
            r_mask        <= '0;
            r_last_vector <= '0;
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_count[t]  <= COUNT_MAX;
                r_reload[t] <= COUNT_MAX;
                r_rld_en[t] <= 1'b0;
                for (int s = 0; s < REGS_PER_CHAN; s++) begin
                    r_chan[t][s] <= '0;
                end
            end
        end else if (i_go) begin
            r_pending     <= n_pending;
            r_mask        <= n_mask;
            r_last_vector <= n_last_vector;
            r_count       <= n_count;
            r_reload      <= n_reload;
            r_rld_en      <= n_rld_en;
            r_chan        <= n_chan;
        end
    end

endmodule

`default_nettype wire

// ===== design/itc_out_reg.sv =====
// Result register that holds one finished item until the consumer takes it.
`default_nettype none

module itc_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire itc_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output itc_pkg::t_result      o_result
);
    import itc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== design/interrupt_controller_with_timers.sv =====
// Top level of the interrupt controller with three countdown timers.
// Takes one item per cycle (tick, word read, word write or raised source) while the result
// register is not stalled, and returns one result per item in order. An accepted item waits in
// the input register, then the whole state update and read mux run in a single combinational
// pass into the result register; only a stalled result register holds the input side back.
// All state resets at once; there is no clearing pass.
`default_nettype none

module interrupt_controller_with_timers (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_addr,
    input  wire logic [31:0] i_wdata,
    input  wire logic [4:0]  i_source,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_rdata,
    output logic             o_fiq_request,
    output logic             o_irq_request
);
    import itc_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_valid;
    logic    go;
    t_result core_result;
    t_result out_result;

    assign in_item = '{kind: i_kind, addr: i_addr, wdata: i_wdata, source: i_source};
    assign go      = held_valid && (!out_valid || i_ready);

    itc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (go),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    itc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (held_item),
        .o_result (core_result)
    );

    itc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (go),
        .i_result (core_result),
        .i_ready  (i_ready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_valid       = out_valid;
    assign o_rdata       = out_result.rdata;
    assign o_fiq_request = out_result.fiq_request;
    assign o_irq_request = out_result.irq_request;

endmodule

`default_nettype wire

// ===== design/itc_checker.sv =====
// Port-level checks for the interrupt controller with timers, bound to the top level.
`default_nettype none

module itc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_rdata
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while result side can move");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> ##1 o_valid)
        else $error("accepted item produced no result in two cycles");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rdata)))
        else $error("stalled result dropped or changed");

endmodule

bind interrupt_controller_with_timers itc_checker u_itc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rdata (o_rdata)
);

`default_nettype wire

// ===== tb/sv/itc_result_checker.sv =====
// Checker for the interrupt controller: predicts each result from accepted items and compares.
`timescale 1ns / 1ps

module itc_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_item_valid,
    input  wire logic        i_item_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_addr,
    input  wire logic [31:0] i_wdata,
    input  wire logic [4:0]  i_source,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [31:0] i_rdata,
    input  wire logic        i_fiq,
    input  wire logic        i_irq,
    output int               o_fail_count = 0,
    output int               o_waiting = 0,
    output int               o_checked = 0
);
    import itc_pkg::*;

    logic [31:0] irq_pending;
    logic [31:0] irq_mask;
    logic [31:0] last_vec;
    logic [15:0] tmr_count [TIMER_COUNT];
    logic [15:0] tmr_reload [TIMER_COUNT];
    logic        tmr_reload_en [TIMER_COUNT];
    logic [31:0] chan_word [TIMER_COUNT*REGS_PER_CHAN];

    t_result expected_results [$];
    t_result want;
    t_result next_res;

    // word index of a timer register, -1 for the count register
    function automatic bit decode_timer(input logic [31:0] a, output int ch, output int word);
        ch = int'(a[7:6]);
        word = -2;
        if (a[31:8] == TIMER_PAGE && a[1:0] == 2'b00) begin
            case (a[5:2])
                4'd0, 4'd1: word = int'(a[5:2]);
                4'd4: word = -1;
                4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: word = int'(a[5:2]) - 3;
                default: word = -2;
            endcase
        end
        return (word != -2) && (ch < TIMER_COUNT);
    endfunction

    task automatic step_controller(input logic [1:0] kind, input logic [31:0] addr,
                                   input logic [31:0] wdata, input logic [4:0] source,
                                   output t_result r);
        int ch;
        int word;
        int sr;
        bit found;
        logic [31:0] vec;
        logic [31:0] req;
        r = '0;
        case (t_kind'(kind))
            KIND_TICK: begin
                for (int t = 0; t < TIMER_COUNT; t++) begin
                    sr = t*REGS_PER_CHAN + int'(SLOT_SR);
                    if (tmr_count[t] == 16'h0) begin
                        tmr_count[t] = tmr_reload_en[t] ? tmr_reload[t] : COUNT_MAX;
                        irq_pending[(TIMER_IRQ_FIRST + t) % 32] = 1'b1;
                        chan_word[sr][STATUS_BIT] = 1'b1;
                    end else begin
                        tmr_count[t] = tmr_count[t] - 16'h1;
                        if (tmr_count[t] == COUNT_WARN) begin
                            chan_word[sr][STATUS_BIT] = 1'b1;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (decode_timer(addr, ch, word)) begin
                    if (word < 0) begin
                        r.rdata = {16'h0, tmr_count[ch]};
                    end else begin
                        r.rdata = chan_word[ch*REGS_PER_CHAN + word];
                        if (word == int'(SLOT_SR)) begin
                            chan_word[ch*REGS_PER_CHAN + word][STATUS_BIT] = 1'b0;
                        end
                    end
                end else begin
                    case (addr)
                        ADDR_IVR: begin
                            found = 1'b0;
                            vec = '0;
                            for (int i = 0; i < 32; i++) begin
                                if (!found && irq_pending[i]) begin
                                    vec = i;
                                    found = 1'b1;
                                end
                            end
                            if (found) begin
                                irq_pending[vec[4:0]] = 1'b0;
                            end
                            last_vec = vec;
                            r.rdata = vec;
                        end
                        ADDR_LVR: r.rdata = last_vec;
                        ADDR_IMR_A, ADDR_IMR_B, ADDR_IECR: r.rdata = irq_mask;
                        ADDR_ID: r.rdata = ID_WORD;
                        default: r.rdata = ALL_ONES;
                    endcase
                end
            end
            KIND_WRITE: begin
                if (decode_timer(addr, ch, word)) begin
                    if (word == -1 || word == int'(SLOT_RC)) begin
                        tmr_count[ch] = wdata[15:0];
                        tmr_reload[ch] = wdata[15:0];
                    end
                    if (word >= 0) begin
                        chan_word[ch*REGS_PER_CHAN + word] = wdata;
                    end
                    if (word == int'(SLOT_CCR)) begin
                        tmr_reload_en[ch] = !wdata[1];
                    end
                end else begin
                    case (addr)
                        ADDR_IECR: irq_mask = irq_mask | wdata;
                        ADDR_IDCR: irq_mask = irq_mask & ~wdata;
                        ADDR_ICCR: irq_pending = irq_pending & ~wdata;
                        default: ;
                    endcase
                end
            end
            default: irq_pending[source] = 1'b1;
        endcase
        req = irq_pending & irq_mask;
        r.fiq_request = |(req & FIQ_MASK);
        r.irq_request = |(req & IRQ_MASK);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            irq_pending = '0;
            irq_mask = '0;
            last_vec = '0;
            for (int t = 0; t < TIMER_COUNT; t++) begin
                tmr_count[t] = COUNT_MAX;
                tmr_reload[t] = COUNT_MAX;
                tmr_reload_en[t] = 1'b0;
            end
            for (int i = 0; i < TIMER_COUNT*REGS_PER_CHAN; i++) begin
                chan_word[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: rdata %h fiq %b irq %b",
                             $time, i_rdata, i_fiq, i_irq);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (i_rdata !== want.rdata) begin
                        $display("%0t: rdata expected %h actual %h", $time, want.rdata, i_rdata);
                        o_fail_count++;
                    end
                    if (i_fiq !== want.fiq_request) begin
                        $display("%0t: fiq_request expected %b actual %b",
                                 $time, want.fiq_request, i_fiq);
                        o_fail_count++;
                    end
                    if (i_irq !== want.irq_request) begin
                        $display("%0t: irq_request expected %b actual %b",
                                 $time, want.irq_request, i_irq);
                        o_fail_count++;
                    end
                end
            end
            if (i_item_valid && i_item_ready) begin
                step_controller(i_kind, i_addr, i_wdata, i_source, next_res);
                expected_results.push_back(next_res);
            end
        end
        o_waiting = expected_results.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: clock, reset, directed and random items, output stalls and the verdict.
`timescale 1ns / 1ps

module tb;
    import itc_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [5:0] OFF_CCR = 6'h00;
    localparam logic [5:0] OFF_CMR = 6'h04;
    localparam logic [5:0] OFF_CV  = 6'h10;
    localparam logic [5:0] OFF_RA  = 6'h14;
    localparam logic [5:0] OFF_RB  = 6'h18;
    localparam logic [5:0] OFF_RC  = 6'h1c;
    localparam logic [5:0] OFF_SR  = 6'h20;
    localparam logic [5:0] OFF_IER = 6'h24;
    localparam logic [5:0] OFF_IDR = 6'h28;
    localparam logic [5:0] OFF_IMR = 6'h2c;
    localparam logic [5:0] OFF_GAP = 6'h08;
    localparam logic [5:0] OFF_END = 6'h30;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  item_kind;
    logic [31:0] item_addr;
    logic [31:0] item_wdata;
    logic [4:0]  item_source;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_rdata;
    logic        res_fiq;
    logic        res_irq;

    int fail_count;
    int waiting;
    int checked;
    int cycle_count = 0;
    int calm_left = 0;
    int ready_hold = 0;
    int n_tick = 0;
    int n_read = 0;
    int n_write = 0;
    int n_raise = 0;

    interrupt_controller_with_timers u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (item_valid),
        .o_ready       (item_ready),
        .i_kind        (item_kind),
        .i_addr        (item_addr),
        .i_wdata       (item_wdata),
        .i_source      (item_source),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_rdata       (res_rdata),
        .o_fiq_request (res_fiq),
        .o_irq_request (res_irq)
    );

    itc_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item_valid (item_valid),
        .i_item_ready (item_ready),
        .i_kind       (item_kind),
        .i_addr       (item_addr),
        .i_wdata      (item_wdata),
        .i_source     (item_source),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_rdata      (res_rdata),
        .i_fiq        (res_fiq),
        .i_irq        (res_irq),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, waiting);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stall the result side in runs, mostly short, some long
    always @(negedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (r < 10) begin
            res_ready <= 1'b1;
            ready_hold <= $urandom_range(20, 80);
        end else if (r < 60) begin
            res_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end else if (r < 97) begin
            res_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
        end else begin
            res_ready <= 1'b0;
            ready_hold <= $urandom_range(10, 50);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 3) begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] timer_reg(input logic [1:0] ch, input logic [5:0] off);
        return {TIMER_PAGE, ch, off};
    endfunction

    function automatic logic [5:0] random_offset();
        case ($urandom_range(0, 12))
            0: return OFF_CCR;
            1: return OFF_CMR;
            2: return OFF_CV;
            3: return OFF_RA;
            4: return OFF_RB;
            5: return OFF_RC;
            6: return OFF_SR;
            7: return OFF_IER;
            8: return OFF_IDR;
            9: return OFF_IMR;
            10: return OFF_GAP;
            11: return OFF_END;
            default: return 6'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_kind k, input logic [31:0] a, input logic [31:0] w,
                             input logic [4:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item_kind <= k;
        item_addr <= a;
        item_wdata <= w;
        item_source <= s;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
        case (k)
            KIND_TICK: n_tick++;
            KIND_READ: n_read++;
            KIND_WRITE: n_write++;
            default: n_raise++;
        endcase
    endtask

    task automatic send_random();
        int pick;
        int r;
        logic [1:0] ch;
        logic [31:0] a;
        logic [31:0] w;
        logic [4:0] s;
        a = $urandom;
        w = $urandom;
        s = 5'($urandom);
        pick = $urandom_range(0, 99);
        ch = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, TIMER_COUNT - 1));
        if (pick < 25) begin
            send_item(KIND_TICK, a, w, s);
        end else if (pick < 45) begin
            send_item(KIND_READ, ADDR_IVR, w, s);
        end else if (pick < 53) begin
            case ($urandom_range(0, 4))
                0: a = ADDR_LVR;
                1: a = ADDR_IMR_A;
                2: a = ADDR_IMR_B;
                3: a = ADDR_IECR;
                default: a = ADDR_ID;
            endcase
            send_item(KIND_READ, a, w, s);
        end else if (pick < 65) begin
            send_item(KIND_READ, timer_reg(ch, random_offset()), w, s);
        end else if (pick < 78) begin
            r = $urandom_range(0, 99);
            if (r < 70) w[15:0] = 16'($urandom_range(0, 12));
            else if (r < 90) w[15:0] = COUNT_WARN + 16'($urandom_range(0, 3));
            send_item(KIND_WRITE, timer_reg(ch, $urandom_range(0, 1) ? OFF_CV : OFF_RC), w, s);
        end else if (pick < 84) begin
            send_item(KIND_WRITE, timer_reg(ch, random_offset()), w, s);
        end else if (pick < 92) begin
            case ($urandom_range(0, 2))
                0: a = ADDR_IECR;
                1: begin
                    a = ADDR_IDCR;
                    w = w & $urandom & $urandom;
                end
                default: a = ADDR_ICCR;
            endcase
            send_item(KIND_WRITE, a, w, s);
        end else if (pick < 97) begin
            send_item(KIND_RAISE, a, w, s);
        end else begin
            send_item($urandom_range(0, 1) ? KIND_READ : KIND_WRITE, a, w, s);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_kind = KIND_TICK;
        item_addr = '0;
        item_wdata = '0;
        item_source = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(KIND_READ, ADDR_ID, '0, '0);
        send_item(KIND_READ, ADDR_IVR, ALL_ONES, 5'd31);
        send_item(KIND_WRITE, ADDR_IECR, ALL_ONES, '0);
        send_item(KIND_RAISE, ALL_ONES, ALL_ONES, 5'd0);
        send_item(KIND_RAISE, '0, '0, 5'd31);
        send_item(KIND_RAISE, '0, '0, 5'd17);
        send_item(KIND_READ, ADDR_IVR, '0, '0);
        send_item(KIND_READ, ADDR_LVR, '0, '0);
        send_item(KIND_READ, ADDR_IMR_A, '0, '0);
        send_item(KIND_READ, ADDR_IMR_B, '0, '0);
        send_item(KIND_READ, ADDR_IECR, '0, '0);
        send_item(KIND_WRITE, ADDR_ICCR, ALL_ONES, '0);
        send_item(KIND_WRITE, timer_reg(2'd0, OFF_CV), 32'h0, '0);
        send_item(KIND_WRITE, timer_reg(2'd1, OFF_RC), 32'hffff1001, '0);
        send_item(KIND_WRITE, timer_reg(2'd2, OFF_CCR), 32'h2, '0);
        send_item(KIND_WRITE, timer_reg(2'd2, OFF_CV), 32'h0, '0);
        send_item(KIND_TICK, '0, '0, '0);
        send_item(KIND_READ, timer_reg(2'd1, OFF_SR), '0, '0);
        send_item(KIND_READ, timer_reg(2'd1, OFF_SR), '0, '0);
        send_item(KIND_READ, timer_reg(2'd2, OFF_CV), '0, '0);
        send_item(KIND_READ, timer_reg(2'd3, OFF_CCR), '0, '0);
        send_item(KIND_READ, timer_reg(2'd0, 6'h01), '0, '0);
        send_item(KIND_READ, 32'h0, '0, '0);
        send_item(KIND_WRITE, ALL_ONES, ALL_ONES, '0);
        send_item(KIND_WRITE, ADDR_IDCR, ALL_ONES, '0);

        repeat (RANDOM_ITEMS) send_random();
        item_valid <= 1'b0;

        while (waiting != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("items sent: %0d ticks, %0d reads, %0d writes, %0d raised sources",
                 n_tick, n_read, n_write, n_raise);
        $display("%0d results compared against the predicted controller and timer state",
                 checked);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
